>>> hdl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, constants and the character map of the glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int DEFAULT_SHEET_WIDTH = 1024;
  localparam int GLYPH_ROWS          = 8;
  localparam int GLYPH_COLS          = 7;
  localparam int STORE_ADDR_W        = 13;
  localparam int STORE_DEPTH         = 1 << STORE_ADDR_W;
  localparam int OFFSET_W            = 10;
  localparam int CELL_W              = 3;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [STORE_ADDR_W-1:0] addr;
    logic                    ink;
    logic [OFFSET_W-1:0]     offset;
    logic [15:0]             x;
    logic [15:0]             y;
    logic [7:0]              color;
  } cmd_t;

  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
  } glyph_map_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } back_state_t;

  function automatic glyph_map_t glyph_lookup(input logic [7:0] code);
    glyph_map_t          m;
    logic [4:0]          idx;
    logic [OFFSET_W-1:0] step;
    m.hit    = 1'b1;
    m.offset = '0;
    idx      = '0;
    step     = OFFSET_W'(GLYPH_COLS);
    if (code >= 8'h41 && code <= 8'h5A) begin
      idx      = 5'(code - 8'h41);
      m.offset = OFFSET_W'(idx) * step;
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      idx      = 5'(code - 8'h61);
      m.offset = (OFFSET_W'(idx) + 10'd29) * step;
    end else if (code >= 8'h30 && code <= 8'h39) begin
      idx      = 5'(code - 8'h30);
      m.offset = 10'd406 + OFFSET_W'(idx) * step;
    end else begin
      unique case (code)
        8'h20:        m.offset = 10'd700;
        8'h28:        m.offset = 10'd511;
        8'h29:        m.offset = 10'd518;
        8'h3A, 8'h2E: m.offset = 10'd476;
        8'h2C:        m.offset = 10'd483;
        8'h21:        m.offset = 10'd490;
        8'h3F:        m.offset = 10'd497;
        8'hE5, 8'hC5: m.offset = 10'd385;
        8'hE4, 8'hC4: m.offset = 10'd392;
        8'hF6, 8'hD6: m.offset = 10'd399;
        8'h25:        m.offset = 10'd504;
        8'h7E:        m.offset = 10'd525;
        8'h2F:        m.offset = 10'd532;
        8'h5C:        m.offset = 10'd539;
        8'h2D:        m.offset = 10'd546;
        8'h5F:        m.offset = 10'd553;
        8'h2B:        m.offset = 10'd560;
        8'h3D:        m.offset = 10'd567;
        8'h40:        m.offset = 10'd574;
        8'h23:        m.offset = 10'd581;
        8'h24:        m.offset = 10'd588;
        8'h22:        m.offset = 10'd595;
        8'h27:        m.offset = 10'd602;
        8'h5B:        m.offset = 10'd609;
        8'h5D:        m.offset = 10'd616;
        8'h7B:        m.offset = 10'd623;
        8'h7D:        m.offset = 10'd630;
        8'h26:        m.offset = 10'd637;
        8'h3C:        m.offset = 10'd644;
        8'h3E:        m.offset = 10'd651;
        8'h7C:        m.offset = 10'd658;
        default:      m.hit    = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

>>> hdl/bgr_front.sv
// ----------------------------------------------------------------------------
// bgr_front
// Accepts items, maps character codes and builds commands for the queue.
// ----------------------------------------------------------------------------
module bgr_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [bgr_pkg::STORE_ADDR_W-1:0] sheet_address,
  input  logic [7:0]                    sheet_byte,
  input  logic [7:0]                    char_code,
  input  logic signed [15:0]            origin_x,
  input  logic signed [15:0]            origin_y,
  input  logic [7:0]                    ink_color,
  input  logic                          q_full,
  output logic                          push,
  output bgr_pkg::cmd_t                 cmd
);

  bgr_pkg::glyph_map_t gmap;

  always_comb begin
    gmap       = bgr_pkg::glyph_lookup(char_code);
    cmd.kind   = kind;
    cmd.addr   = sheet_address;
    cmd.ink    = (sheet_byte == 8'd0);
    cmd.offset = gmap.offset;
    cmd.x      = origin_x;
    cmd.y      = origin_y;
    cmd.color  = ink_color;
  end

  // drop draw items with an unmapped code
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && (kind == bgr_pkg::KIND_LOAD || gmap.hit);

endmodule

>>> hdl/bgr_queue.sv
// ----------------------------------------------------------------------------
// bgr_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module bgr_queue #(
  parameter int DEPTH = bgr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bgr_pkg::cmd_t wdata,
  input  logic          pop,
  output bgr_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bgr_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rdata = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST_PTR) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == LAST_PTR) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/bgr_back.sv
// ----------------------------------------------------------------------------
// bgr_back
// Ink store, glyph cell scan and pixel output register.
// ----------------------------------------------------------------------------
module bgr_back #(
  parameter int SHEET_WIDTH = bgr_pkg::DEFAULT_SHEET_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  bgr_pkg::cmd_t      cmd,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [7:0]         pixel_color,
  output logic               last
);

  localparam int AW = bgr_pkg::STORE_ADDR_W;
  localparam int CW = bgr_pkg::CELL_W;
  localparam logic [AW-1:0] ROW_STEP = AW'(SHEET_WIDTH);
  localparam logic [CW-1:0] LAST_ROW = CW'(bgr_pkg::GLYPH_ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(bgr_pkg::GLYPH_COLS - 1);

  logic                ink_mem [bgr_pkg::STORE_DEPTH];

  bgr_pkg::back_state_t state, state_next;

  logic [CW-1:0]       row, col;
  logic [AW-1:0]       row_base;
  logic [bgr_pkg::OFFSET_W-1:0] offset;
  logic [15:0]         org_x, org_y;
  logic [7:0]          color;

  logic                s_valid;
  logic [CW-1:0]       s_row, s_col;
  logic                rd_ink;

  logic                p_valid;
  logic [15:0]         p_x, p_y;

  logic                advance, issue, final_cell, ink_hit, emit, emit_last;
  logic [AW-1:0]       raddr;
  logic [15:0]         hit_x, hit_y;

  assign advance    = !out_valid || !out_stall;
  assign final_cell = (row == LAST_ROW) && (col == LAST_COL);
  assign raddr      = row_base + AW'(offset) + AW'(col);
  assign ink_hit    = s_valid && rd_ink;
  assign hit_x      = org_x + 16'(s_col);
  assign hit_y      = org_y + 16'(LAST_ROW - s_row);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      bgr_pkg::ST_IDLE: begin
        pop = !q_empty;
        if (!q_empty && cmd.kind == bgr_pkg::KIND_DRAW) begin
          state_next = bgr_pkg::ST_SCAN;
        end
      end
      bgr_pkg::ST_SCAN: begin
        issue = advance;
        emit  = ink_hit && p_valid;
        if (advance && final_cell) begin
          state_next = bgr_pkg::ST_DRAIN;
        end
      end
      bgr_pkg::ST_DRAIN: begin
        emit = ink_hit && p_valid;
        if (advance) begin
          state_next = bgr_pkg::ST_FLUSH;
        end
      end
      bgr_pkg::ST_FLUSH: begin
        emit      = p_valid;
        emit_last = 1'b1;
        if (advance) begin
          state_next = bgr_pkg::ST_IDLE;
        end
      end
      default: state_next = bgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == bgr_pkg::KIND_LOAD) begin
      ink_mem[cmd.addr] <= cmd.ink;
    end
    if (advance) begin
      rd_ink <= ink_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bgr_pkg::ST_IDLE;
      s_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        s_valid   <= issue;
        out_valid <= emit;
        if (state == bgr_pkg::ST_FLUSH) begin
          p_valid <= 1'b0;
        end else if (ink_hit) begin
          p_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == bgr_pkg::KIND_DRAW) begin
      row      <= '0;
      col      <= '0;
      row_base <= '0;
      offset   <= cmd.offset;
      org_x    <= cmd.x;
      org_y    <= cmd.y;
      color    <= cmd.color;
    end else if (issue) begin
      if (col == LAST_COL) begin
        col      <= '0;
        row      <= row + 1'b1;
        row_base <= row_base + ROW_STEP;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (issue) begin
      s_row <= row;
      s_col <= col;
    end
    if (advance && ink_hit && state != bgr_pkg::ST_FLUSH) begin
      p_x <= hit_x;
      p_y <= hit_y;
    end
    if (advance && emit) begin
      pixel_x     <= p_x;
      pixel_y     <= p_y;
      pixel_color <= color;
      last        <= emit_last;
    end
  end

endmodule

>>> hdl/bitmap_glyph_renderer.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_renderer
// Bitmap font character generator with a one-bit-per-byte ink store.
// ----------------------------------------------------------------------------
// A load item is taken from the queue by the idle back end and writes one
// ink bit. A draw item with a mapped code scans the 8 by 7 glyph cell at one
// store read per cycle while the output is not stalled: the back end fetches
// the command, makes the 56 reads, drains the read stage and sends the final
// pixel. Unmapped codes are dropped at the input and cost no back-end time.
// A command queue, four entries by default, lets input items be taken while
// a character is still being drawn. Pixels of one character leave in
// row-then-column order; the last one carries last high.
// ----------------------------------------------------------------------------
module bitmap_glyph_renderer #(
  parameter int SHEET_WIDTH = bgr_pkg::DEFAULT_SHEET_WIDTH,
  parameter int QUEUE_DEPTH = bgr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [12:0]        sheet_address,
  input  logic [7:0]         sheet_byte,
  input  logic [7:0]         char_code,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic [7:0]         ink_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [7:0]         pixel_color,
  output logic               last
);

  bgr_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, q_full, q_empty;

  bgr_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .sheet_address (sheet_address),
    .sheet_byte    (sheet_byte),
    .char_code     (char_code),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .ink_color     (ink_color),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  bgr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  bgr_back #(
    .SHEET_WIDTH (SHEET_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

>>> hdl/bgr_checker.sv
// ----------------------------------------------------------------------------
// bgr_checker
// Port-level checks of the glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
module bgr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] pixel_x,
  input logic signed [15:0] pixel_y,
  input logic [7:0]         pixel_color,
  input logic               last
);

  logic out_take;
  assign out_take = out_valid && !out_stall;

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(last))
    else $error("stalled pixel changed");

  a_color_same: assert property (@(posedge clk) disable iff (rst)
    out_take && !last ##1 out_take |-> pixel_color == $past(pixel_color))
    else $error("color changed within a character");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_take && !last ##1 out_take |->
      ($past(pixel_y) - pixel_y) <= 16'd7)
    else $error("pixel rows out of order within a character");

endmodule

bind bitmap_glyph_renderer bgr_checker u_bgr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .last        (last)
);

>>> verif/bitmap_glyph_renderer_tb.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_renderer_tb
// Self-checking bench for the glyph renderer. The two glyph cells that draws
// read are loaded first: the 'A' cell fully inked, the shared Latin-1 ring
// cell blank. Directed loads and draws follow: coordinate wrap, unmapped and
// blank codes, sparse glyphs and shared offsets. Then random loads and draws,
// on codes with loaded cells and on unmapped codes, run under several
// input-idle and output-stall mixes. Expected pixel writes are computed
// from a local copy of the ink store at input acceptance. They are compared
// field by field at output acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_glyph_renderer_tb;

  localparam int SHEET_W   = bgr_pkg::DEFAULT_SHEET_WIDTH;
  localparam int ROWS      = bgr_pkg::GLYPH_ROWS;
  localparam int COLS      = bgr_pkg::GLYPH_COLS;
  localparam int NO_GLYPH  = -1;
  localparam int BLANK_COL = 700;
  localparam int FULL_COL  = 0;
  localparam int RING_COL  = 385;
  localparam int PHASE_ITEMS = 15;

  typedef struct packed {
    logic               kind;
    logic [12:0]        addr;
    logic [7:0]         sheet_val;
    logic [7:0]         code;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [7:0]         color;
  } glyph_cmd_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         color;
    logic               last_flag;
  } pixel_write_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = bgr_pkg::KIND_LOAD;
  logic [12:0]        sheet_address = '0;
  logic [7:0]         sheet_byte = '0;
  logic [7:0]         char_code = '0;
  logic signed [15:0] origin_x = '0;
  logic signed [15:0] origin_y = '0;
  logic [7:0]         ink_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         pixel_color;
  logic               last;

  glyph_cmd_t   cmd_feed[$];
  pixel_write_t pending_pixels[$];
  bit           ink_sheet[bgr_pkg::STORE_DEPTH];
  glyph_cmd_t   cur_cmd;
  pixel_write_t got_px;
  pixel_write_t exp_px;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           error_count = 0;

  bitmap_glyph_renderer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .sheet_address (sheet_address),
    .sheet_byte    (sheet_byte),
    .char_code     (char_code),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .ink_color     (ink_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_color   (pixel_color),
    .last          (last)
  );

  function automatic int glyph_column(input logic [7:0] code);
    int c;
    c = int'(code);
    if (c >= 'h41 && c <= 'h5A) return COLS * (c - 'h41);
    if (c >= 'h61 && c <= 'h7A) return COLS * (c - 'h61 + 29);
    if (c >= 'h30 && c <= 'h39) return 406 + COLS * (c - 'h30);
    case (code)
      8'h20:        return BLANK_COL;
      8'h2E, 8'h3A: return 476;
      8'h2C:        return 483;
      8'h21:        return 490;
      8'h3F:        return 497;
      8'h25:        return 504;
      8'h28:        return 511;
      8'h29:        return 518;
      8'h7E:        return 525;
      8'h2F:        return 532;
      8'h5C:        return 539;
      8'h2D:        return 546;
      8'h5F:        return 553;
      8'h2B:        return 560;
      8'h3D:        return 567;
      8'h40:        return 574;
      8'h23:        return 581;
      8'h24:        return 588;
      8'h22:        return 595;
      8'h27:        return 602;
      8'h5B:        return 609;
      8'h5D:        return 616;
      8'h7B:        return 623;
      8'h7D:        return 630;
      8'h26:        return 637;
      8'h3C:        return 644;
      8'h3E:        return 651;
      8'h7C:        return 658;
      8'hC5, 8'hE5: return 385;
      8'hC4, 8'hE4: return 392;
      8'hD6, 8'hF6: return 399;
      default:      return NO_GLYPH;
    endcase
  endfunction

  function automatic void render_glyph(input glyph_cmd_t c);
    int           base;
    logic [12:0]  a;
    pixel_write_t held;
    bit           have;
    base = glyph_column(c.code);
    have = 1'b0;
    held = '0;
    if (base == NO_GLYPH) return;
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < COLS; k++) begin
        a = 13'(r * SHEET_W + base + k);
        if (ink_sheet[a]) begin
          if (have) pending_pixels.push_back(held);
          held.x         = c.ox + 16'(k);
          held.y         = c.oy + 16'(ROWS - 1 - r);
          held.color     = c.color;
          held.last_flag = 1'b0;
          have           = 1'b1;
        end
      end
    end
    if (have) begin
      held.last_flag = 1'b1;
      pending_pixels.push_back(held);
    end
  endfunction

  function automatic void apply_item(input glyph_cmd_t c);
    if (c.kind == bgr_pkg::KIND_LOAD) ink_sheet[c.addr] = (c.sheet_val == 8'd0);
    else render_glyph(c);
  endfunction

  function automatic glyph_cmd_t random_cmd();
    glyph_cmd_t c;
    c.kind      = bgr_pkg::KIND_DRAW;
    c.addr      = 13'($urandom_range(0, bgr_pkg::STORE_DEPTH - 1));
    c.sheet_val = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
    c.code      = 8'($urandom_range(0, 255));
    c.ox        = 16'($urandom_range(0, 65535));
    c.oy        = 16'($urandom_range(0, 65535));
    c.color     = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic push_load(input int addr, input int val);
    glyph_cmd_t c;
    c           = random_cmd();
    c.kind      = bgr_pkg::KIND_LOAD;
    c.addr      = 13'(addr);
    c.sheet_val = 8'(val);
    cmd_feed.push_back(c);
  endtask

  task automatic push_draw(input logic [7:0] code, input int x, input int y, input int color);
    glyph_cmd_t c;
    c       = random_cmd();
    c.code  = code;
    c.ox    = 16'(x);
    c.oy    = 16'(y);
    c.color = 8'(color);
    cmd_feed.push_back(c);
  endtask

  task automatic push_random(input int count);
    glyph_cmd_t c;
    int         cell_col;
    for (int i = 0; i < count; i++) begin
      c = random_cmd();
      if ($urandom_range(0, 99) < 30) begin
        c.kind = bgr_pkg::KIND_LOAD;
        if ($urandom_range(0, 99) < 80) begin
          cell_col = $urandom_range(0, 1) ? RING_COL : FULL_COL;
          c.addr   = 13'(int'($urandom_range(0, ROWS - 1)) * SHEET_W + cell_col
                         + int'($urandom_range(0, COLS - 1)));
        end
      end else if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0:       c.code = 8'h41;
          1:       c.code = 8'hE5;
          default: c.code = 8'hC5;
        endcase
      end else begin
        while (glyph_column(c.code) != NO_GLYPH) c.code = 8'($urandom_range(0, 255));
      end
      cmd_feed.push_back(c);
    end
  endtask

  task automatic drain_all();
    while (cmd_feed.size() != 0 || in_valid || pending_pixels.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_item(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (cmd_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_cmd       = cmd_feed.pop_front();
          kind          <= cur_cmd.kind;
          sheet_address <= cur_cmd.addr;
          sheet_byte    <= cur_cmd.sheet_val;
          char_code     <= cur_cmd.code;
          origin_x      <= cur_cmd.ox;
          origin_y      <= cur_cmd.oy;
          ink_color     <= cur_cmd.color;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      got_px = '{pixel_x, pixel_y, pixel_color, last};
      if (pending_pixels.size() == 0) begin
        error_count++;
        $display("%0t: expected no pixel, actual x=%0d y=%0d color=%0d last=%0b", $time,
                 got_px.x, got_px.y, got_px.color, got_px.last_flag);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (got_px != exp_px) begin
          error_count++;
          $display(
              "%0t: expected x=%0d y=%0d c=%0d last=%0b, actual x=%0d y=%0d c=%0d last=%0b",
              $time, exp_px.x, exp_px.y, exp_px.color, exp_px.last_flag,
              got_px.x, got_px.y, got_px.color, got_px.last_flag);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("bitmap_glyph_renderer verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Load every sheet byte a draw can read: 'A' fully inked, ring cell blank.
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < COLS; k++) begin
        push_load(r * SHEET_W + FULL_COL + k, 0);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int k = 0; k < COLS; k++) begin
        push_load(r * SHEET_W + RING_COL + k, $urandom_range(1, 255));
      end
    end
    push_draw(8'h41, 32767, 32767, 255);
    push_draw(8'h41, -32768, -32768, 0);
    push_draw(8'hE5, 10, -10, 4);
    push_draw(8'h00, 0, 0, 1);
    push_draw(8'hFF, -1, -1, 2);
    push_draw(8'h80, 5, 5, 3);
    push_load(RING_COL, 0);
    push_load(3 * SHEET_W + RING_COL + 2, 0);
    push_load(7 * SHEET_W + RING_COL + 6, 0);
    push_draw(8'hC5, 32765, -32766, 5);
    push_draw(8'hE5, -3, 32762, 6);
    push_load(0, 255);
    push_load(ROWS * SHEET_W - 1 - (SHEET_W - COLS), 255);
    push_load(bgr_pkg::STORE_DEPTH - 1, 0);
    push_draw(8'h41, 0, 0, 8'hA5);
    push_load(0, 0);
    push_draw(8'h41, -100, 100, 8'h5A);
    push_random(PHASE_ITEMS);
    drain_all();
    idle_pct  = 49;
    stall_pct = 0;
    push_random(PHASE_ITEMS);
    drain_all();
    idle_pct  = 0;
    stall_pct = 49;
    push_random(PHASE_ITEMS);
    drain_all();
    idle_pct  = 35;
    stall_pct = 35;
    push_random(PHASE_ITEMS);
    drain_all();
    repeat (300) @(negedge clk);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("bitmap_glyph_renderer verification clean");
    end else begin
      $display("bitmap_glyph_renderer verification failed");
    end
    $finish;
  end

endmodule
